>>> design/cra_pkg.sv
// Shared types and constants for the 8-bit register/ALU execute unit.
// No dependencies; used by every module of the unit.
`timescale 1ns / 1ps
`default_nettype none

package cra_pkg;

  typedef enum logic [3:0] {
    CMD_LD8      = 4'd0,
    CMD_LD16     = 4'd1,
    CMD_ADD      = 4'd2,
    CMD_XOR      = 4'd3,
    CMD_CP       = 4'd4,
    CMD_INC8     = 4'd5,
    CMD_DEC8     = 4'd6,
    CMD_INC16    = 4'd7,
    CMD_DEC16    = 4'd8,
    CMD_ADDHL    = 4'd9,
    CMD_ADDSP    = 4'd10,
    CMD_TEST     = 4'd11,
    CMD_READPAIR = 4'd12
  } cmd_t;

  localparam int unsigned NUM_BYTE_REGS = 7;

  // byte register codes
  localparam logic [2:0] REG_B    = 3'd0;
  localparam logic [2:0] REG_C    = 3'd1;
  localparam logic [2:0] REG_D    = 3'd2;
  localparam logic [2:0] REG_E    = 3'd3;
  localparam logic [2:0] REG_H    = 3'd4;
  localparam logic [2:0] REG_L    = 3'd5;
  localparam logic [2:0] REG_A    = 3'd6;
  localparam logic [2:0] SEL_NONE = 3'd7;  // src: immediate byte, dst: no register

  // pair codes
  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic TEST_CARRY = 1'b1;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  dst_sel;
    logic [2:0]  src_sel;
    logic [1:0]  pair_sel;
    logic [15:0] imm;
    logic        test_flag;
    logic        test_value;
  } item_t;

  // register file read view
  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  src_byte;
    logic [7:0]  dst_byte;
    logic [15:0] pair;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [3:0]  flags;
  } rd_t;

  // register file write request
  typedef struct packed {
    logic        byte_we;
    logic [2:0]  byte_idx;
    logic [7:0]  byte_data;
    logic        pair_we;
    logic [1:0]  pair_idx;
    logic [15:0] pair_data;
    logic [3:0]  flags;
  } wr_t;

  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  flags;
    logic [15:0] pair_value;
    logic        cond_met;
  } res_t;

endpackage

`default_nettype wire

>>> design/cra_regfile.sv
// Architectural state: seven byte registers, stack pointer and flags.
// Depends on cra_pkg for the read/write structs and register codes.
`timescale 1ns / 1ps
`default_nettype none

module cra_regfile (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [2:0]    src_sel,
  input  wire logic [2:0]    dst_sel,
  input  wire logic [1:0]    pair_sel,
  input  wire logic          wr_en,
  input  wire cra_pkg::wr_t  wr,
  output cra_pkg::rd_t       rd
);

  logic [7:0]  byte_regs [cra_pkg::NUM_BYTE_REGS];
  logic [15:0] stack_ptr;
  logic [3:0]  flag_bits;

  always_comb begin
    rd          = '0;
    rd.a        = byte_regs[cra_pkg::REG_A];
    rd.hl       = {byte_regs[cra_pkg::REG_H], byte_regs[cra_pkg::REG_L]};
    rd.sp       = stack_ptr;
    rd.flags    = flag_bits;
    // selector code 7 reads as zero here; the immediate is muxed in later
    for (int i = 0; i < cra_pkg::NUM_BYTE_REGS; i++) begin
      if (src_sel == 3'(i)) rd.src_byte = byte_regs[i];
      if (dst_sel == 3'(i)) rd.dst_byte = byte_regs[i];
    end
    case (pair_sel)
      cra_pkg::PAIR_BC: rd.pair = {byte_regs[cra_pkg::REG_B], byte_regs[cra_pkg::REG_C]};
      cra_pkg::PAIR_DE: rd.pair = {byte_regs[cra_pkg::REG_D], byte_regs[cra_pkg::REG_E]};
      cra_pkg::PAIR_HL: rd.pair = {byte_regs[cra_pkg::REG_H], byte_regs[cra_pkg::REG_L]};
      default:          rd.pair = stack_ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cra_pkg::NUM_BYTE_REGS; i++) byte_regs[i] <= '0;
      stack_ptr <= '0;
      flag_bits <= '0;
    end else if (wr_en) begin
      flag_bits <= wr.flags;
      if (wr.byte_we) begin
        for (int i = 0; i < cra_pkg::NUM_BYTE_REGS; i++) begin
          if (wr.byte_idx == 3'(i)) byte_regs[i] <= wr.byte_data;
        end
      end
      if (wr.pair_we) begin
        case (wr.pair_idx)
          cra_pkg::PAIR_BC: begin
            byte_regs[cra_pkg::REG_B] <= wr.pair_data[15:8];
            byte_regs[cra_pkg::REG_C] <= wr.pair_data[7:0];
          end
          cra_pkg::PAIR_DE: begin
            byte_regs[cra_pkg::REG_D] <= wr.pair_data[15:8];
            byte_regs[cra_pkg::REG_E] <= wr.pair_data[7:0];
          end
          cra_pkg::PAIR_HL: begin
            byte_regs[cra_pkg::REG_H] <= wr.pair_data[15:8];
            byte_regs[cra_pkg::REG_L] <= wr.pair_data[7:0];
          end
          default: stack_ptr <= wr.pair_data;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> design/cra_exec.sv
// Execute logic: ALU, flag rules and register write request for one item.
// Depends on cra_pkg; fed by cra_regfile read data.
`timescale 1ns / 1ps
`default_nettype none

module cra_exec (
  input  wire cra_pkg::item_t item,
  input  wire cra_pkg::rd_t   rd,
  output cra_pkg::wr_t        wr,
  output cra_pkg::res_t       res
);

  logic [7:0]  s;
  logic [8:0]  add9;
  logic [4:0]  add_nib;
  logic [8:0]  sub9;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [16:0] hl_sum;
  logic [12:0] hl_low;
  logic [8:0]  sp_low;
  logic [4:0]  sp_nib;
  logic [15:0] sp_sum;
  logic [3:0]  f;
  logic        dst_ok;

  always_comb begin
    s       = (item.src_sel == cra_pkg::SEL_NONE) ? item.imm[7:0] : rd.src_byte;
    add9    = {1'b0, rd.a} + {1'b0, s};
    add_nib = {1'b0, rd.a[3:0]} + {1'b0, s[3:0]};
    sub9    = {1'b0, rd.a} - {1'b0, s};
    inc8    = rd.dst_byte + 8'd1;
    dec8    = rd.dst_byte - 8'd1;
    hl_sum  = {1'b0, rd.hl} + {1'b0, rd.pair};
    hl_low  = {1'b0, rd.hl[11:0]} + {1'b0, rd.pair[11:0]};
    sp_low  = {1'b0, rd.sp[7:0]} + {1'b0, item.imm[7:0]};
    sp_nib  = {1'b0, rd.sp[3:0]} + {1'b0, item.imm[3:0]};
    sp_sum  = rd.sp + {{8{item.imm[7]}}, item.imm[7:0]};
    dst_ok  = (item.dst_sel != cra_pkg::SEL_NONE);

    f            = rd.flags;
    wr           = '0;
    wr.byte_idx  = item.dst_sel;
    wr.pair_idx  = item.pair_sel;
    res          = '0;
    res.pair_value = rd.pair;

    case (item.cmd)
      cra_pkg::CMD_LD8: begin
        if (dst_ok) begin
          wr.byte_we   = 1'b1;
          wr.byte_data = s;
          res.value    = {8'd0, s};
        end
      end
      cra_pkg::CMD_LD16: begin
        wr.pair_we   = 1'b1;
        wr.pair_data = item.imm;
        res.value    = item.imm;
      end
      cra_pkg::CMD_ADD: begin
        f                   = '0;
        f[cra_pkg::FLAG_Z]  = (add9[7:0] == 8'd0);
        f[cra_pkg::FLAG_H]  = add_nib[4];
        f[cra_pkg::FLAG_C]  = add9[8];
        wr.byte_we          = 1'b1;
        wr.byte_idx         = cra_pkg::REG_A;
        wr.byte_data        = add9[7:0];
        res.value           = {8'd0, add9[7:0]};
      end
      cra_pkg::CMD_XOR: begin
        f                   = '0;
        f[cra_pkg::FLAG_Z]  = ((rd.a ^ s) == 8'd0);
        wr.byte_we          = 1'b1;
        wr.byte_idx         = cra_pkg::REG_A;
        wr.byte_data        = rd.a ^ s;
        res.value           = {8'd0, rd.a ^ s};
      end
      cra_pkg::CMD_CP: begin
        f                   = '0;
        f[cra_pkg::FLAG_N]  = 1'b1;
        f[cra_pkg::FLAG_Z]  = (sub9[7:0] == 8'd0);
        f[cra_pkg::FLAG_H]  = (s[3:0] > rd.a[3:0]);
        f[cra_pkg::FLAG_C]  = sub9[8];
        res.value           = {8'd0, sub9[7:0]};
      end
      cra_pkg::CMD_INC8: begin
        if (dst_ok) begin
          f[cra_pkg::FLAG_Z] = (inc8 == 8'd0);
          f[cra_pkg::FLAG_N] = 1'b0;
          f[cra_pkg::FLAG_H] = (rd.dst_byte[3:0] == 4'hF);
          wr.byte_we         = 1'b1;
          wr.byte_data       = inc8;
          res.value          = {8'd0, inc8};
        end
      end
      cra_pkg::CMD_DEC8: begin
        if (dst_ok) begin
          f[cra_pkg::FLAG_Z] = (dec8 == 8'd0);
          f[cra_pkg::FLAG_N] = 1'b1;
          f[cra_pkg::FLAG_H] = (rd.dst_byte[3:0] == 4'h0);
          wr.byte_we         = 1'b1;
          wr.byte_data       = dec8;
          res.value          = {8'd0, dec8};
        end
      end
      cra_pkg::CMD_INC16: begin
        wr.pair_we   = 1'b1;
        wr.pair_data = rd.pair + 16'd1;
        res.value    = rd.pair + 16'd1;
      end
      cra_pkg::CMD_DEC16: begin
        wr.pair_we   = 1'b1;
        wr.pair_data = rd.pair - 16'd1;
        res.value    = rd.pair - 16'd1;
      end
      cra_pkg::CMD_ADDHL: begin
        f[cra_pkg::FLAG_N] = 1'b0;
        f[cra_pkg::FLAG_H] = hl_low[12];
        f[cra_pkg::FLAG_C] = hl_sum[16];
        wr.pair_we         = 1'b1;
        wr.pair_idx        = cra_pkg::PAIR_HL;
        wr.pair_data       = hl_sum[15:0];
        res.value          = hl_sum[15:0];
      end
      cra_pkg::CMD_ADDSP: begin
        // H and C come from the unsigned low-byte add, not the signed sum
        f                  = '0;
        f[cra_pkg::FLAG_H] = sp_nib[4];
        f[cra_pkg::FLAG_C] = sp_low[8];
        wr.pair_we         = 1'b1;
        wr.pair_idx        = cra_pkg::PAIR_SP;
        wr.pair_data       = sp_sum;
        res.value          = sp_sum;
      end
      cra_pkg::CMD_TEST: begin
        res.cond_met = ((item.test_flag == cra_pkg::TEST_CARRY) ? rd.flags[cra_pkg::FLAG_C]
                        : rd.flags[cra_pkg::FLAG_Z]) == item.test_value;
      end
      cra_pkg::CMD_READPAIR: begin
        res.value = rd.pair;
      end
      default: begin
      end
    endcase

    wr.flags  = f;
    res.flags = f;
  end

endmodule

`default_nettype wire

>>> design/cpu8_register_alu_unit_top.sv
// Path: input register -> execute -> result register, both registers held on a stall.
// Throughput: one item per cycle while out_stall does not hold the output.
// Each item sees the register state left by the previous one, updated as it executes.
// Reset (rst, synchronous): byte registers, stack pointer and flags clear to zero,
// both stages empty. Depends on cra_pkg, cra_regfile and cra_exec.
`timescale 1ns / 1ps
`default_nettype none

module cpu8_register_alu_unit_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  cmd,
  input  wire logic [2:0]  dst_sel,
  input  wire logic [2:0]  src_sel,
  input  wire logic [1:0]  pair_sel,
  input  wire logic [15:0] imm,
  input  wire logic        test_flag,
  input  wire logic        test_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      value,
  output logic [3:0]       flags,
  output logic [15:0]      pair_value,
  output logic             cond_met
);

  cra_pkg::item_t item;
  logic           item_valid;
  cra_pkg::rd_t   rd;
  cra_pkg::wr_t   wr;
  cra_pkg::res_t  res;
  logic           out_free;
  logic           adv;

  assign out_free = !out_valid || !out_stall;
  assign adv      = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.cmd        <= cra_pkg::cmd_t'(cmd);
      item.dst_sel    <= dst_sel;
      item.src_sel    <= src_sel;
      item.pair_sel   <= pair_sel;
      item.imm        <= imm;
      item.test_flag  <= test_flag;
      item.test_value <= test_value;
    end
  end

  cra_regfile u_regfile (
    .clk      (clk),
    .rst      (rst),
    .src_sel  (item.src_sel),
    .dst_sel  (item.dst_sel),
    .pair_sel (item.pair_sel),
    .wr_en    (adv),
    .wr       (wr),
    .rd       (rd)
  );

  cra_exec u_exec (
    .item (item),
    .rd   (rd),
    .wr   (wr),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value      <= res.value;
      flags      <= res.flags;
      pair_value <= res.pair_value;
      cond_met   <= res.cond_met;
    end
  end

  // only a test command can report a met condition
  a_cond_only_test: assert property (@(posedge clk) disable iff (rst)
    (adv && item.cmd != cra_pkg::CMD_TEST) |=> !cond_met)
    else $error("cond_met set for a non-test command");

  // xor clears N, H and C
  a_xor_flags: assert property (@(posedge clk) disable iff (rst)
    (adv && item.cmd == cra_pkg::CMD_XOR) |=> (flags[2:0] == 3'b000))
    else $error("xor left N/H/C set");

  // compare always sets N and leaves the result register loaded
  a_cp_sets_n: assert property (@(posedge clk) disable iff (rst)
    (adv && item.cmd == cra_pkg::CMD_CP) |=> (out_valid && flags[cra_pkg::FLAG_N]))
    else $error("cp result missing or N clear");

  // a held item is never dropped while the output is blocked
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !out_free) |=> (item_valid && $stable(item)))
    else $error("pending item lost while output stalled");

endmodule

`default_nettype wire
